// File: rtl/dense_layer_inference_assert.svh
// assertion macros used by the dense layer checker
`ifndef DENSE_LAYER_INFERENCE_ASSERT_SVH
`define DENSE_LAYER_INFERENCE_ASSERT_SVH

// same-cycle implication, checked at every rising edge outside reset
`define DLI_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dense layer check failed");

// next-cycle implication, checked at every rising edge outside reset
`define DLI_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dense layer check failed");

`endif

// File: rtl/dli_pkg.sv
// shared types, codes, tables and output arithmetic of the dense layer
package dli_pkg;

   localparam int DATA_W = 16;
   localparam int ACC_W  = 40;
   localparam int PROD_W = 2 * DATA_W;
   localparam int SUM_W  = ACC_W + 1;
   localparam int FRAC_W = 8;

   // operation codes of an input item
   localparam logic [1:0] OP_WEIGHT = 2'd0;
   localparam logic [1:0] OP_BIAS   = 2'd1;
   localparam logic [1:0] OP_FEED   = 2'd2;

   // activation codes
   localparam logic [1:0] ACT_LINEAR  = 2'd0;
   localparam logic [1:0] ACT_RELU    = 2'd1;
   localparam logic [1:0] ACT_SIGMOID = 2'd2;
   localparam logic [1:0] ACT_TANH    = 2'd3;

   // register port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 5;
   localparam logic [CSR_IDX_W-1:0] CSR_ACT_MODE       = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INPUTS_IN_USE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NEURONS_IN_USE = 2'd2;
   localparam logic [1:0] ACT_MODE_RESET       = ACT_LINEAR;
   localparam logic [4:0] INPUTS_IN_USE_RESET  = 5'd16;
   localparam logic [4:0] NEURONS_IN_USE_RESET = 5'd16;

   typedef struct packed {
      logic [1:0]               operation;
      logic [3:0]               neuron_sel;
      logic [3:0]               input_sel;
      logic signed [DATA_W-1:0] value;
      logic                     last_input;
   } dli_req_type;

   typedef struct packed {
      logic [3:0]               neuron_out;
      logic signed [DATA_W-1:0] activation_value;
      logic                     last_output;
   } dli_rsp_type;

   // control broadcast along the row of neuron cells
   typedef struct packed {
      logic wt_we;
      logic bias_we;
      logic acc_en;
      logic capture;
      logic shift;
   } dli_cell_ctl_type;

   // 256 / (1 + e^(m/16)) rounded, m = 0..99; zero beyond
   localparam int SIG_LEN = 100;
   localparam logic [7:0] SIG_LUT [0:SIG_LEN-1] = '{
      8'd128, 8'd124, 8'd120, 8'd116, 8'd112, 8'd108, 8'd104, 8'd100,
      8'd97,  8'd93,  8'd89,  8'd86,  8'd82,  8'd79,  8'd75,  8'd72,
      8'd69,  8'd66,  8'd63,  8'd60,  8'd57,  8'd54,  8'd52,  8'd49,
      8'd47,  8'd44,  8'd42,  8'd40,  8'd38,  8'd36,  8'd34,  8'd32,
      8'd31,  8'd29,  8'd27,  8'd26,  8'd24,  8'd23,  8'd22,  8'd21,
      8'd19,  8'd18,  8'd17,  8'd16,  8'd15,  8'd15,  8'd14,  8'd13,
      8'd12,  8'd11,  8'd11,  8'd10,  8'd10,  8'd9,   8'd8,   8'd8,
      8'd8,   8'd7,   8'd7,   8'd6,   8'd6,   8'd6,   8'd5,   8'd5,
      8'd5,   8'd4,   8'd4,   8'd4,   8'd4,   8'd3,   8'd3,   8'd3,
      8'd3,   8'd3,   8'd2,   8'd2,   8'd2,   8'd2,   8'd2,   8'd2,
      8'd2,   8'd2,   8'd2,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,
      8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,
      8'd1,   8'd1,   8'd1,   8'd1
   };

   // 256 * tanh(m/16) rounded, m = 0..55; 256 beyond
   localparam int TANH_LEN = 56;
   localparam logic [8:0] TANH_LUT [0:TANH_LEN-1] = '{
      9'd0,   9'd16,  9'd32,  9'd47,  9'd63,  9'd77,  9'd92,  9'd105,
      9'd118, 9'd131, 9'd142, 9'd153, 9'd163, 9'd172, 9'd180, 9'd188,
      9'd195, 9'd201, 9'd207, 9'd212, 9'd217, 9'd221, 9'd225, 9'd229,
      9'd232, 9'd234, 9'd237, 9'd239, 9'd241, 9'd243, 9'd244, 9'd246,
      9'd247, 9'd248, 9'd249, 9'd250, 9'd250, 9'd251, 9'd252, 9'd252,
      9'd253, 9'd253, 9'd253, 9'd254, 9'd254, 9'd254, 9'd254, 9'd255,
      9'd255, 9'd255, 9'd255, 9'd255, 9'd255, 9'd255, 9'd255, 9'd255
   };
   localparam logic [8:0] TANH_TOP = 9'd256;
   localparam logic [8:0] SIG_ONE  = 9'd256;

   localparam logic signed [SUM_W-FRAC_W-1:0] Q_MAX = 33'sd32767;
   localparam logic signed [SUM_W-FRAC_W-1:0] Q_MIN = -33'sd32768;
   localparam logic signed [DATA_W-1:0] CLAMP_MAX = 16'sd2047;
   localparam logic signed [DATA_W-1:0] CLAMP_MIN = -16'sd2048;

   // floor back to Q8.8 and saturate
   function automatic logic signed [DATA_W-1:0] sat_q88(input logic signed [SUM_W-1:0] s);
      logic signed [SUM_W-FRAC_W-1:0] q;
      logic signed [DATA_W-1:0]       r;
      q = s[SUM_W-1:FRAC_W];
      if (q > Q_MAX) begin
         r = Q_MAX[DATA_W-1:0];
      end else if (q < Q_MIN) begin
         r = Q_MIN[DATA_W-1:0];
      end else begin
         r = q[DATA_W-1:0];
      end
      return r;
   endfunction

   // linear, relu, or sigmoid/tanh table over sixteenths in [-8, 8)
   function automatic logic signed [DATA_W-1:0] activate(input logic [1:0] mode,
                                                         input logic signed [DATA_W-1:0] x);
      logic signed [DATA_W-1:0] c;
      logic [7:0]               p;
      logic [7:0]               m;
      logic [7:0]               sig_mag;
      logic [8:0]               sig_val;
      logic [8:0]               tanh_mag;
      logic signed [DATA_W-1:0] r;
      if (x < CLAMP_MIN) begin
         c = CLAMP_MIN;
      end else if (x > CLAMP_MAX) begin
         c = CLAMP_MAX;
      end else begin
         c = x;
      end
      p = c[11:4];
      m = p[7] ? (~p + 8'd1) : p;
      sig_mag  = (m < 8'(SIG_LEN)) ? SIG_LUT[m[6:0]] : 8'd0;
      tanh_mag = (m < 8'(TANH_LEN)) ? TANH_LUT[m[5:0]] : TANH_TOP;
      sig_val  = p[7] ? {1'b0, sig_mag} : (SIG_ONE - {1'b0, sig_mag});
      unique case (mode)
         ACT_LINEAR: begin
            r = x;
         end
         ACT_RELU: begin
            r = x[DATA_W-1] ? '0 : x;
         end
         ACT_SIGMOID: begin
            r = $signed({7'd0, sig_val});
         end
         ACT_TANH: begin
            r = p[7] ? -$signed({7'd0, tanh_mag}) : $signed({7'd0, tanh_mag});
         end
      endcase
      return r;
   endfunction

endpackage

// File: rtl/dense_layer_inference.sv
// dense layer: a row of neuron cells accumulating broadcast samples
// weight writes, bias writes and samples are taken one per cycle while the layer is not busy
// after the sample marked last, stages a, b, c, the shift row and p1 lead to the first
// result, then one per cycle unless rsp_ready stalls, as the row shifts toward cell 0;
// no item is taken until the last result of the vector has been transferred
// reset clears accumulators, pipeline control and registers to their defaults;
// weights and biases keep their contents
module dense_layer_inference #(
   parameter int MAX_NEURONS = 16,
   parameter int MAX_INPUTS  = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  dli_pkg::dli_req_type            req_payload,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output dli_pkg::dli_rsp_type            rsp_payload,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [dli_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [dli_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import dli_pkg::*;

   localparam int IAW  = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
   localparam int ICW  = $clog2(MAX_INPUTS + 1);
   localparam int ICMP = (ICW > 5) ? ICW : 5;
   localparam int NCW  = $clog2(MAX_NEURONS + 1);
   localparam int NCMP = (NCW > 5) ? NCW : 5;

   // registers
   logic [1:0]              act_mode_ff, act_mode_in;
   logic [4:0]              inputs_in_use_ff, inputs_in_use_in;
   logic [4:0]              neurons_in_use_ff, neurons_in_use_in;

   // sample pipeline
   logic                    busy_ff, busy_in;
   logic                    a_valid_ff, a_valid_in;
   logic                    a_last_ff, a_last_in;
   logic signed [DATA_W-1:0] x_a_ff, x_a_in;
   logic                    b_valid_ff, b_valid_in;
   logic                    b_last_ff, b_last_in;
   logic                    c_last_ff, c_last_in;

   // result drain
   logic [NCW-1:0]          rem_ff, rem_in;
   logic [3:0]              idx_ff, idx_in;
   logic                    p1_valid_ff, p1_valid_in;
   logic signed [DATA_W-1:0] p1_sat_ff, p1_sat_in;
   logic [3:0]              p1_idx_ff, p1_idx_in;
   logic                    p1_last_ff, p1_last_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   dli_rsp_type             rsp_payload_ff, rsp_payload_in;

   logic                    req_xfer;
   logic                    is_feed;
   logic                    wt_in_range;
   logic [ICMP-1:0]         in_lim;
   logic [NCMP-1:0]         n_lim;
   logic                    adv;
   logic                    drain_go;
   logic [IAW-1:0]          cell_addr;
   dli_cell_ctl_type        ctl;
   logic [MAX_NEURONS-1:0]  cell_sel;
   logic signed [SUM_W-1:0] chain [MAX_NEURONS+1];

   assign req_ready = !busy_ff;
   assign csr_ready = 1'b1;
   assign req_xfer  = req_valid && req_ready;
   assign is_feed   = (req_payload.operation == OP_FEED);
   assign cell_addr = IAW'(req_payload.input_sel);
   assign adv       = !rsp_valid_ff || rsp_ready;
   assign drain_go  = adv && (rem_ff != '0);

   // register writes
   always_comb begin
      act_mode_in       = act_mode_ff;
      inputs_in_use_in  = inputs_in_use_ff;
      neurons_in_use_in = neurons_in_use_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_ACT_MODE:       act_mode_in       = csr_wdata[1:0];
            CSR_INPUTS_IN_USE:  inputs_in_use_in  = csr_wdata;
            CSR_NEURONS_IN_USE: neurons_in_use_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // effective counts: zero counts as one, above the maximum as the maximum
   always_comb begin
      if (inputs_in_use_ff == '0) begin
         in_lim = ICMP'(1);
      end else if (ICMP'(inputs_in_use_ff) > ICMP'(MAX_INPUTS)) begin
         in_lim = ICMP'(MAX_INPUTS);
      end else begin
         in_lim = ICMP'(inputs_in_use_ff);
      end
      if (neurons_in_use_ff == '0) begin
         n_lim = NCMP'(1);
      end else if (NCMP'(neurons_in_use_ff) > NCMP'(MAX_NEURONS)) begin
         n_lim = NCMP'(MAX_NEURONS);
      end else begin
         n_lim = NCMP'(neurons_in_use_ff);
      end
   end

   assign wt_in_range = ICMP'(req_payload.input_sel) < ICMP'(MAX_INPUTS);

   // sample pipeline: ram read, product, accumulate, then capture into the shift row
   always_comb begin
      a_valid_in = req_xfer && is_feed && (ICMP'(req_payload.input_sel) < in_lim);
      a_last_in  = req_xfer && is_feed && req_payload.last_input;
      x_a_in     = req_xfer ? req_payload.value : x_a_ff;
      b_valid_in = a_valid_ff;
      b_last_in  = a_last_ff;
      c_last_in  = b_last_ff;
   end

   // cell control broadcast
   always_comb begin
      ctl.wt_we   = req_xfer && (req_payload.operation == OP_WEIGHT) && wt_in_range;
      ctl.bias_we = req_xfer && (req_payload.operation == OP_BIAS);
      ctl.acc_en  = b_valid_ff;
      ctl.capture = c_last_ff;
      ctl.shift   = drain_go;
   end

   // busy from the last sample until the last result transfer
   always_comb begin
      busy_in = busy_ff;
      if (a_last_in) begin
         busy_in = 1'b1;
      end else if (rsp_valid_ff && rsp_ready && rsp_payload_ff.last_output) begin
         busy_in = 1'b0;
      end
   end

   // drain: saturate the head of the row, then activate into the output register
   always_comb begin
      if (c_last_ff) begin
         rem_in = NCW'(n_lim);
         idx_in = '0;
      end else if (drain_go) begin
         rem_in = rem_ff - NCW'(1);
         idx_in = idx_ff + 4'd1;
      end else begin
         rem_in = rem_ff;
         idx_in = idx_ff;
      end
      p1_valid_in    = p1_valid_ff;
      p1_sat_in      = p1_sat_ff;
      p1_idx_in      = p1_idx_ff;
      p1_last_in     = p1_last_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      if (adv) begin
         p1_valid_in    = drain_go;
         p1_sat_in      = sat_q88(chain[0]);
         p1_idx_in      = idx_ff;
         p1_last_in     = (rem_ff == NCW'(1));
         rsp_valid_in   = p1_valid_ff;
         rsp_payload_in.neuron_out       = p1_idx_ff;
         rsp_payload_in.activation_value = activate(act_mode_ff, p1_sat_ff);
         rsp_payload_in.last_output      = p1_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_mode_ff       <= ACT_MODE_RESET;
         inputs_in_use_ff  <= INPUTS_IN_USE_RESET;
         neurons_in_use_ff <= NEURONS_IN_USE_RESET;
         busy_ff           <= 1'b0;
         a_valid_ff        <= 1'b0;
         a_last_ff         <= 1'b0;
         b_valid_ff        <= 1'b0;
         b_last_ff         <= 1'b0;
         c_last_ff         <= 1'b0;
         rem_ff            <= '0;
         idx_ff            <= '0;
         p1_valid_ff       <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         act_mode_ff       <= act_mode_in;
         inputs_in_use_ff  <= inputs_in_use_in;
         neurons_in_use_ff <= neurons_in_use_in;
         busy_ff           <= busy_in;
         a_valid_ff        <= a_valid_in;
         a_last_ff         <= a_last_in;
         b_valid_ff        <= b_valid_in;
         b_last_ff         <= b_last_in;
         c_last_ff         <= c_last_in;
         rem_ff            <= rem_in;
         idx_ff            <= idx_in;
         p1_valid_ff       <= p1_valid_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_a_ff         <= x_a_in;
      p1_sat_ff      <= p1_sat_in;
      p1_idx_ff      <= p1_idx_in;
      p1_last_ff     <= p1_last_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   // row of neuron cells, shifting results toward cell 0
   assign chain[MAX_NEURONS] = '0;

   for (genvar g = 0; g < MAX_NEURONS; g++) begin : g_cell
      assign cell_sel[g] = (32'(req_payload.neuron_sel) == 32'(g));

      dli_cell #(
         .DEPTH (MAX_INPUTS)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl),
         .sel       (cell_sel[g]),
         .addr      (cell_addr),
         .value     (req_payload.value),
         .x         (x_a_ff),
         .chain_in  (chain[g+1]),
         .chain_out (chain[g])
      );
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

// File: rtl/dli_ram.sv
// generic simple dual-port ram with registered read
module dli_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                       wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                       rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;
   logic [WIDTH-1:0] rdata_in;

   assign rdata_in = mem_ff[raddr];
   assign rdata    = rdata_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= rdata_in;
   end

endmodule

// File: rtl/dli_cell.sv
// one neuron cell: weight ram, bias, multiply-accumulate and output shift stage
module dli_cell #(
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  dli_pkg::dli_cell_ctl_type              ctl,
   input  logic                                   sel,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
   input  logic signed [dli_pkg::DATA_W-1:0]      value,
   input  logic signed [dli_pkg::DATA_W-1:0]      x,
   input  logic signed [dli_pkg::SUM_W-1:0]       chain_in,
   output logic signed [dli_pkg::SUM_W-1:0]       chain_out
);
   import dli_pkg::*;

   logic [DATA_W-1:0]        wt_rdata;
   logic signed [DATA_W-1:0] bias_ff;
   logic signed [DATA_W-1:0] bias_in;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ACC_W-1:0]  acc_in;
   logic signed [SUM_W-1:0]  shift_ff;
   logic signed [SUM_W-1:0]  shift_in;

   // weights of this neuron, one per input position
   dli_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_wt_ram (
      .clock (clock),
      .we    (ctl.wt_we && sel),
      .waddr (addr),
      .wdata (value),
      .raddr (addr),
      .rdata (wt_rdata)
   );

   // bias write, product, accumulate with wrap, capture and shift toward cell 0
   always_comb begin
      bias_in = (ctl.bias_we && sel) ? value : bias_ff;
      prod_in = $signed(wt_rdata) * x;
      if (ctl.capture) begin
         acc_in = '0;
      end else if (ctl.acc_en) begin
         acc_in = acc_ff + ACC_W'(prod_ff);
      end else begin
         acc_in = acc_ff;
      end
      if (ctl.capture) begin
         shift_in = SUM_W'(acc_ff) + (SUM_W'(bias_ff) <<< FRAC_W);
      end else if (ctl.shift) begin
         shift_in = chain_in;
      end else begin
         shift_in = shift_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      bias_ff  <= bias_in;
      prod_ff  <= prod_in;
      shift_ff <= shift_in;
   end

   assign chain_out = shift_ff;

endmodule

// File: rtl/dli_checker.sv
// port-level checks of the dense layer result stream, bound to the top level
`include "dense_layer_inference_assert.svh"

module dli_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input dli_pkg::dli_rsp_type rsp_payload
);
   import dli_pkg::*;

   logic rsp_xfer;

   assign rsp_xfer = rsp_valid && rsp_ready;

   // a stalled result holds
   `DLI_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload))

   // no input transfer while results are pending
   `DLI_ASSERT_IMP(a_no_overlap, clock, reset, rsp_valid, !req_ready)

   // each vector starts at neuron zero
   `DLI_ASSERT_IMP(a_first_zero, clock, reset, $rose(rsp_valid), rsp_payload.neuron_out == 4'd0)

   // results follow back to back in neuron order
   `DLI_ASSERT_NXT(a_in_order, clock, reset, rsp_xfer && !rsp_payload.last_output, rsp_valid && (rsp_payload.neuron_out == 4'($past(rsp_payload.neuron_out) + 4'd1)))

   // nothing follows the final neuron of a vector at once
   `DLI_ASSERT_NXT(a_end_gap, clock, reset, rsp_xfer && rsp_payload.last_output, !rsp_valid)

endmodule

bind dense_layer_inference dli_checker u_dli_checker (.*);
